// File: hdl/qfe_pkg.sv
// qfe_pkg: shared types, codes and saturating helpers for the quadratic
// free-energy evaluator; no dependencies
package qfe_pkg;

  localparam int VAL_W = 48;
  localparam int MUL_LAT = 4;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic sat;
    val_t v;
  } sres_t;

  localparam val_t VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  // opcodes
  localparam logic [2:0] OP_ENERGY = 3'd0;
  localparam logic [2:0] OP_DERIV  = 3'd1;
  localparam logic [2:0] OP_SECOND = 3'd2;
  localparam logic [2:0] OP_SPLIT  = 3'd3;
  localparam logic [2:0] OP_EQ     = 3'd4;

  // register indexes
  localparam logic [2:0] REG_REF_TEMP = 3'd0;
  localparam logic [2:0] REG_LIQ_CURV = 3'd1;
  localparam logic [2:0] REG_LIQ_EQ   = 3'd2;
  localparam logic [2:0] REG_LIQ_SLOPE = 3'd3;
  localparam logic [2:0] REG_SOL_CURV = 3'd4;
  localparam logic [2:0] REG_SOL_EQ   = 3'd5;
  localparam logic [2:0] REG_SOL_SLOPE = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_ZERODIV = 2'd2;

  function automatic sres_t sat49(input logic [VAL_W:0] s);
    sres_t r;
    if (s[VAL_W] != s[VAL_W-1]) begin
      r.sat = 1'b1;
      r.v = s[VAL_W] ? VMIN : VMAX;
    end else begin
      r.sat = 1'b0;
      r.v = s[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic sres_t sat_add(input val_t a, input val_t b);
    return sat49({a[VAL_W-1], a} + {b[VAL_W-1], b});
  endfunction

  function automatic sres_t sat_sub(input val_t a, input val_t b);
    return sat49({a[VAL_W-1], a} - {b[VAL_W-1], b});
  endfunction

  function automatic sres_t sat_dbl(input val_t a);
    return sat49({a, 1'b0});
  endfunction

endpackage

// File: hdl/quadratic_free_energy_eval.sv
// quadratic_free_energy_eval: top level of the quadratic free-energy evaluator
// start to done runs through five multiplier passes and the bit-per-stage divider
// throughput: one item per cycle, busy is never raised; done pulses one cycle
// reset clears the valid pipeline and loads register defaults (curvatures 1.0)
// uses qfe_pkg, qfe_fmul, qfe_fdiv, qfe_delay
module quadratic_free_energy_eval #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           opcode,
  input  logic                 phase_sel,
  input  logic                 grand_flag,
  input  logic [46:0]          temperature,
  input  logic signed [47:0]   concentration,
  input  logic signed [47:0]   phase_fraction,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [47:0]          wr_data,
  output logic                 done,
  output logic signed [47:0]   result_a,
  output logic signed [47:0]   result_b,
  output logic signed [47:0]   result_c,
  output logic signed [47:0]   result_d,
  output logic [1:0]           status
);

  localparam int M = qfe_pkg::MUL_LAT;
  localparam int DV = 48 + FRAC_BITS + 2;
  localparam qfe_pkg::val_t ONE = qfe_pkg::val_t'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [2:0]    op;
    logic          psel;
    logic          grand;
    qfe_pkg::val_t c;
    qfe_pkg::val_t h;
    qfe_pkg::sres_t g;
    qfe_pkg::sres_t dbl;
  } ctx1_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          psel;
    logic          grand;
    logic          zero;
    logic          sat;
    qfe_pkg::val_t c;
    qfe_pkg::val_t h;
    qfe_pkg::val_t g;
    qfe_pkg::val_t d;
    qfe_pkg::val_t dbl;
    qfe_pkg::val_t eql;
    qfe_pkg::val_t eqs;
    qfe_pkg::val_t den;
    qfe_pkg::val_t aac;
    qfe_pkg::val_t alc;
  } ctx2_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          grand;
    logic          zero;
    logic          sat;
    qfe_pkg::val_t der;
    qfe_pkg::val_t dbl;
    qfe_pkg::val_t eql;
    qfe_pkg::val_t eqs;
    qfe_pkg::val_t den;
    qfe_pkg::val_t aac;
    qfe_pkg::val_t alc;
  } ctx3_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          zero;
    logic          sat;
    qfe_pkg::val_t ra;
    qfe_pkg::val_t rb;
    qfe_pkg::val_t eql;
    qfe_pkg::val_t eqs;
  } ctx4_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          zero;
    logic          sat;
    qfe_pkg::val_t ra;
    qfe_pkg::val_t rb;
    qfe_pkg::val_t cl;
    qfe_pkg::val_t cs;
    qfe_pkg::val_t dl;
    qfe_pkg::val_t ds;
  } ctx5_t;

  // configuration registers
  logic [46:0]   tref;
  qfe_pkg::val_t al, leq, lsl, aa, seq, ssl;

  always_ff @(posedge clk) begin
    if (rst) begin
      tref <= '0;
      al   <= ONE;
      leq  <= '0;
      lsl  <= '0;
      aa   <= ONE;
      seq  <= '0;
      ssl  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        qfe_pkg::REG_REF_TEMP:  tref <= wr_data[46:0];
        qfe_pkg::REG_LIQ_CURV:  al   <= wr_data;
        qfe_pkg::REG_LIQ_EQ:    leq  <= wr_data;
        qfe_pkg::REG_LIQ_SLOPE: lsl  <= wr_data;
        qfe_pkg::REG_SOL_CURV:  aa   <= wr_data;
        qfe_pkg::REG_SOL_EQ:    seq  <= wr_data;
        qfe_pkg::REG_SOL_SLOPE: ssl  <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage
  logic          v0;
  logic [2:0]    op0;
  logic          psel0, grand0;
  logic [46:0]   temp0;
  qfe_pkg::val_t c0, h0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    op0    <= opcode;
    psel0  <= phase_sel;
    grand0 <= grand_flag;
    temp0  <= temperature;
    c0     <= concentration;
    h0     <= phase_fraction;
  end

  qfe_pkg::val_t dt;
  ctx1_t         x1, c1;
  logic          v1;
  qfe_pkg::sres_t m1a, m1b, m1c, m1d, m1e, m1f;

  assign dt = $signed({1'b0, temp0}) - $signed({1'b0, tref});

  always_comb begin
    x1.op    = op0;
    x1.psel  = psel0;
    x1.grand = grand0;
    x1.c     = c0;
    x1.h     = h0;
    x1.g     = qfe_pkg::sat_sub(ONE, h0);
    x1.dbl   = qfe_pkg::sat_dbl(psel0 ? aa : al);
  end

  qfe_fmul #(.FRAC(FRAC_BITS)) u_m1a (.clk(clk), .a(dt),     .b(lsl), .y(m1a));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m1b (.clk(clk), .a(dt),     .b(ssl), .y(m1b));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m1c (.clk(clk), .a(x1.g.v), .b(aa),  .y(m1c));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m1d (.clk(clk), .a(h0),     .b(al),  .y(m1d));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m1e (.clk(clk), .a(aa),     .b(c0),  .y(m1e));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m1f (.clk(clk), .a(al),     .b(c0),  .y(m1f));

  qfe_delay #(.W($bits(ctx1_t)), .N(M)) u_d1 (
    .clk(clk), .rst(rst), .vin(v0), .din(x1), .vout(v1), .dout(c1)
  );

  // equilibrium concentrations, divisor, concentration offset
  qfe_pkg::sres_t eql_s, eqs_s, den_s, dd_s;
  logic           sl, ss, csel, satb;
  ctx2_t          sb, c2;
  logic           vb, v2;

  always_comb begin
    eql_s = qfe_pkg::sat_add(leq, m1a.v);
    eqs_s = qfe_pkg::sat_add(seq, m1b.v);
    den_s = qfe_pkg::sat_add(m1c.v, m1d.v);
    sl    = m1a.sat | eql_s.sat;
    ss    = m1b.sat | eqs_s.sat;
    csel  = c1.psel ? ss : sl;
    dd_s  = qfe_pkg::sat_sub(c1.c, c1.psel ? eqs_s.v : eql_s.v);
    case (c1.op)
      qfe_pkg::OP_ENERGY, qfe_pkg::OP_DERIV: satb = csel | dd_s.sat;
      qfe_pkg::OP_SECOND: satb = c1.dbl.sat;
      qfe_pkg::OP_SPLIT:  satb = c1.g.sat | sl | ss | m1c.sat | m1d.sat | den_s.sat |
                                 m1e.sat | m1f.sat;
      qfe_pkg::OP_EQ:     satb = sl | ss;
      default:            satb = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= v1;
  end

  always_ff @(posedge clk) begin
    sb.op    <= c1.op;
    sb.psel  <= c1.psel;
    sb.grand <= c1.grand;
    sb.zero  <= (al == '0) | (aa == '0) | (den_s.v == '0);
    sb.sat   <= satb;
    sb.c     <= c1.c;
    sb.h     <= c1.h;
    sb.g     <= c1.g.v;
    sb.d     <= dd_s.v;
    sb.dbl   <= c1.dbl.v;
    sb.eql   <= eql_s.v;
    sb.eqs   <= eqs_s.v;
    sb.den   <= den_s.v;
    sb.aac   <= m1e.v;
    sb.alc   <= m1f.v;
  end

  qfe_pkg::sres_t t_s, pl_s, ps_s;

  qfe_fmul #(.FRAC(FRAC_BITS)) u_m2a (.clk(clk), .a(sb.psel ? aa : al), .b(sb.d), .y(t_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m2b (.clk(clk), .a(al), .b(sb.eql), .y(pl_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m2c (.clk(clk), .a(aa), .b(sb.eqs), .y(ps_s));

  qfe_delay #(.W($bits(ctx2_t)), .N(M)) u_d2 (
    .clk(clk), .rst(rst), .vin(vb), .din(sb), .vout(v2), .dout(c2)
  );

  // derivative and equilibrium difference terms
  qfe_pkg::sres_t der_s, xs_s, xl_s;
  logic           satc;
  logic           vc, v3;
  ctx3_t          sc, c3;
  qfe_pkg::val_t  sc_t, sc_d, sc_h, sc_g, sc_c, sc_xs, sc_xl;

  always_comb begin
    der_s = qfe_pkg::sat_dbl(t_s.v);
    xs_s  = qfe_pkg::sat_sub(ps_s.v, pl_s.v);
    xl_s  = qfe_pkg::sat_sub(pl_s.v, ps_s.v);
    case (c2.op)
      qfe_pkg::OP_ENERGY: satc = t_s.sat | (c2.grand & der_s.sat);
      qfe_pkg::OP_DERIV:  satc = t_s.sat | der_s.sat;
      qfe_pkg::OP_SPLIT:  satc = pl_s.sat | ps_s.sat | xs_s.sat | xl_s.sat;
      default:            satc = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= v2;
  end

  always_ff @(posedge clk) begin
    sc.op    <= c2.op;
    sc.grand <= c2.grand;
    sc.zero  <= c2.zero;
    sc.sat   <= c2.sat | satc;
    sc.der   <= der_s.v;
    sc.dbl   <= c2.dbl;
    sc.eql   <= c2.eql;
    sc.eqs   <= c2.eqs;
    sc.den   <= c2.den;
    sc.aac   <= c2.aac;
    sc.alc   <= c2.alc;
    sc_t     <= t_s.v;
    sc_d     <= c2.d;
    sc_h     <= c2.h;
    sc_g     <= c2.g;
    sc_c     <= c2.c;
    sc_xs    <= xs_s.v;
    sc_xl    <= xl_s.v;
  end

  qfe_pkg::sres_t fe_s, hx_s, gx_s, dc_s;

  qfe_fmul #(.FRAC(FRAC_BITS)) u_m3a (.clk(clk), .a(sc_t),   .b(sc_d),  .y(fe_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m3b (.clk(clk), .a(sc_h),   .b(sc_xs), .y(hx_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m3c (.clk(clk), .a(sc_g),   .b(sc_xl), .y(gx_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m3d (.clk(clk), .a(sc.der), .b(sc_c),  .y(dc_s));

  qfe_delay #(.W($bits(ctx3_t)), .N(M)) u_d3 (
    .clk(clk), .rst(rst), .vin(vc), .din(sc), .vout(v3), .dout(c3)
  );

  // energy, grand potential and split numerators
  qfe_pkg::sres_t gp_s, nl_s, ns_s;
  qfe_pkg::val_t  ra_d, rb_d;
  logic           satd;
  logic           vd, v4;
  ctx4_t          sd, c4;
  qfe_pkg::val_t  sd_nl, sd_ns, sd_den;

  always_comb begin
    gp_s = qfe_pkg::sat_sub(fe_s.v, dc_s.v);
    nl_s = qfe_pkg::sat_sub(c3.aac, hx_s.v);
    ns_s = qfe_pkg::sat_sub(c3.alc, gx_s.v);
    rb_d = '0;
    satd = 1'b0;
    case (c3.op)
      qfe_pkg::OP_ENERGY: begin
        ra_d = c3.grand ? gp_s.v : fe_s.v;
        satd = fe_s.sat | (c3.grand & (dc_s.sat | gp_s.sat));
      end
      qfe_pkg::OP_DERIV:  ra_d = c3.der;
      qfe_pkg::OP_SECOND: ra_d = c3.dbl;
      qfe_pkg::OP_SPLIT: begin
        ra_d = '0;
        satd = hx_s.sat | gx_s.sat | nl_s.sat | ns_s.sat;
      end
      qfe_pkg::OP_EQ: begin
        ra_d = c3.eql;
        rb_d = c3.eqs;
      end
      default: ra_d = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else vd <= v3;
  end

  always_ff @(posedge clk) begin
    sd.op   <= c3.op;
    sd.zero <= c3.zero;
    sd.sat  <= c3.sat | satd;
    sd.ra   <= ra_d;
    sd.rb   <= rb_d;
    sd.eql  <= c3.eql;
    sd.eqs  <= c3.eqs;
    sd_nl   <= nl_s.v;
    sd_ns   <= ns_s.v;
    sd_den  <= c3.den;
  end

  qfe_pkg::sres_t ql_s, qs_s;

  qfe_fdiv #(.FRAC(FRAC_BITS)) u_divl (.clk(clk), .n(sd_nl), .d(sd_den), .y(ql_s));
  qfe_fdiv #(.FRAC(FRAC_BITS)) u_divs (.clk(clk), .n(sd_ns), .d(sd_den), .y(qs_s));

  qfe_delay #(.W($bits(ctx4_t)), .N(DV)) u_d4 (
    .clk(clk), .rst(rst), .vin(vd), .din(sd), .vout(v4), .dout(c4)
  );

  // phase concentrations and their offsets
  qfe_pkg::sres_t dl_s, ds_s;
  logic           split4;
  logic           ve, v5, v6;
  ctx5_t          se, c5, x6, c6;

  assign dl_s   = qfe_pkg::sat_sub(ql_s.v, c4.eql);
  assign ds_s   = qfe_pkg::sat_sub(qs_s.v, c4.eqs);
  assign split4 = (c4.op == qfe_pkg::OP_SPLIT);

  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else ve <= v4;
  end

  always_ff @(posedge clk) begin
    se.op   <= c4.op;
    se.zero <= c4.zero;
    se.sat  <= c4.sat | (split4 & (ql_s.sat | qs_s.sat | dl_s.sat | ds_s.sat));
    se.ra   <= c4.ra;
    se.rb   <= c4.rb;
    se.cl   <= ql_s.v;
    se.cs   <= qs_s.v;
    se.dl   <= dl_s.v;
    se.ds   <= ds_s.v;
  end

  qfe_pkg::sres_t tl_s, ts_s, fl_s, fs_s;

  qfe_fmul #(.FRAC(FRAC_BITS)) u_m4a (.clk(clk), .a(al), .b(se.dl), .y(tl_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m4b (.clk(clk), .a(aa), .b(se.ds), .y(ts_s));

  qfe_delay #(.W($bits(ctx5_t)), .N(M)) u_d5 (
    .clk(clk), .rst(rst), .vin(ve), .din(se), .vout(v5), .dout(c5)
  );

  qfe_fmul #(.FRAC(FRAC_BITS)) u_m5a (.clk(clk), .a(tl_s.v), .b(c5.dl), .y(fl_s));
  qfe_fmul #(.FRAC(FRAC_BITS)) u_m5b (.clk(clk), .a(ts_s.v), .b(c5.ds), .y(fs_s));

  always_comb begin
    x6 = c5;
    x6.sat = c5.sat | ((c5.op == qfe_pkg::OP_SPLIT) & (tl_s.sat | ts_s.sat));
  end

  qfe_delay #(.W($bits(ctx5_t)), .N(M)) u_d6 (
    .clk(clk), .rst(rst), .vin(v5), .din(x6), .vout(v6), .dout(c6)
  );

  // result select
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v6;
  end

  always_ff @(posedge clk) begin
    if (c6.op == qfe_pkg::OP_SPLIT) begin
      if (c6.zero) begin
        result_a <= '0;
        result_b <= '0;
        result_c <= '0;
        result_d <= '0;
        status   <= qfe_pkg::ST_ZERODIV;
      end else begin
        result_a <= c6.cl;
        result_b <= c6.cs;
        result_c <= fl_s.v;
        result_d <= fs_s.v;
        status   <= (c6.sat | fl_s.sat | fs_s.sat) ? qfe_pkg::ST_SAT : qfe_pkg::ST_OK;
      end
    end else begin
      result_a <= c6.ra;
      result_b <= c6.rb;
      result_c <= '0;
      result_d <= '0;
      status   <= c6.sat ? qfe_pkg::ST_SAT : qfe_pkg::ST_OK;
    end
  end

endmodule

// File: hdl/qfe_fmul.sv
// qfe_fmul: four-stage fixed-point multiplier, 24x24 partial products,
// truncate toward zero and saturate; uses qfe_pkg
module qfe_fmul #(
  parameter int FRAC = 24
) (
  input  logic           clk,
  input  qfe_pkg::val_t  a,
  input  qfe_pkg::val_t  b,
  output qfe_pkg::sres_t y
);

  logic        neg1, neg2, neg3;
  logic [47:0] ua1, ub1;
  logic [47:0] p00, p01, p10, p11;
  logic [95:0] prod;
  logic [95:0] mag;

  always_ff @(posedge clk) begin
    neg1 <= a[47] ^ b[47];
    ua1  <= a[47] ? 48'(-a) : 48'(a);
    ub1  <= b[47] ? 48'(-b) : 48'(b);
    neg2 <= neg1;
    p00  <= 48'(ua1[23:0]) * 48'(ub1[23:0]);
    p01  <= 48'(ua1[23:0]) * 48'(ub1[47:24]);
    p10  <= 48'(ua1[47:24]) * 48'(ub1[23:0]);
    p11  <= 48'(ua1[47:24]) * 48'(ub1[47:24]);
    neg3 <= neg2;
    prod <= {48'd0, p00} + ({48'd0, p01} << 24) + ({48'd0, p10} << 24) + {p11, 48'd0};
  end

  assign mag = prod >> FRAC;

  always_ff @(posedge clk) begin
    if (neg3) begin
      if ((mag[95:48] != '0) || (mag[47] && (mag[46:0] != '0))) begin
        y <= {1'b1, qfe_pkg::VMIN};
      end else begin
        y <= {1'b0, 48'(-mag[47:0])};
      end
    end else begin
      if (mag[95:47] != '0) begin
        y <= {1'b1, qfe_pkg::VMAX};
      end else begin
        y <= {1'b0, mag[47:0]};
      end
    end
  end

endmodule

// File: hdl/qfe_fdiv.sv
// qfe_fdiv: pipelined restoring divider, one quotient bit per stage,
// fixed-point quotient truncated toward zero and saturated; uses qfe_pkg
module qfe_fdiv #(
  parameter int FRAC = 24
) (
  input  logic           clk,
  input  qfe_pkg::val_t  n,
  input  qfe_pkg::val_t  d,
  output qfe_pkg::sres_t y
);

  localparam int QW = 48 + FRAC;

  logic          neg_q [QW+1];
  logic [47:0]   ud_q  [QW+1];
  logic [QW-1:0] num_q [QW+1];
  logic [47:0]   rem_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [QW-1:0] qf;

  always_ff @(posedge clk) begin
    neg_q[0] <= n[47] ^ d[47];
    ud_q[0]  <= d[47] ? 48'(-d) : 48'(d);
    num_q[0] <= {(n[47] ? 48'(-n) : 48'(n)), {FRAC{1'b0}}};
    rem_q[0] <= '0;
    quo_q[0] <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [48:0] r2;
    logic        ge;
    assign r2 = {rem_q[k], num_q[k][QW-1]};
    assign ge = r2 >= {1'b0, ud_q[k]};
    always_ff @(posedge clk) begin
      neg_q[k+1] <= neg_q[k];
      ud_q[k+1]  <= ud_q[k];
      num_q[k+1] <= num_q[k] << 1;
      rem_q[k+1] <= ge ? 48'(r2 - {1'b0, ud_q[k]}) : r2[47:0];
      quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
    end
  end

  assign qf = quo_q[QW];

  always_ff @(posedge clk) begin
    if (neg_q[QW]) begin
      if ((qf[QW-1:48] != '0) || (qf[47] && (qf[46:0] != '0))) begin
        y <= {1'b1, qfe_pkg::VMIN};
      end else begin
        y <= {1'b0, 48'(-qf[47:0])};
      end
    end else begin
      if (qf[QW-1:47] != '0) begin
        y <= {1'b1, qfe_pkg::VMAX};
      end else begin
        y <= {1'b0, qf[47:0]};
      end
    end
  end

endmodule

// File: hdl/qfe_delay.sv
// qfe_delay: fixed-length delay line for a valid bit and its side data,
// keeps context aligned with multiplier and divider latency; no dependencies
module qfe_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic         vq [N];
  logic [W-1:0] dq [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vq[i] <= 1'b0;
    end else begin
      vq[0] <= vin;
      for (int i = 1; i < N; i++) vq[i] <= vq[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dq[0] <= din;
    for (int i = 1; i < N; i++) dq[i] <= dq[i-1];
  end

  assign vout = vq[N-1];
  assign dout = dq[N-1];

endmodule

// File: sim/tb_quadratic_free_energy_eval.sv
// tb_quadratic_free_energy_eval: self-checking bench for the quadratic free-energy evaluator
// predicts every result in saturating fixed point and checks it on done
// depends on qfe_pkg and hdl/quadratic_free_energy_eval.sv
module tb_quadratic_free_energy_eval;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam longint MAXV = 64'sh7FFF_FFFF_FFFF;
  localparam longint MINV = -64'sh8000_0000_0000;
  localparam int DRAIN_CYCLES = 130;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [47:0] ra, rb, rc, rd;
    logic [1:0] st;
  } energy_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode = '0;
  logic phase_sel = 1'b0;
  logic grand_flag = 1'b0;
  logic [46:0] temperature = '0;
  logic signed [47:0] concentration = '0;
  logic signed [47:0] phase_fraction = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [47:0] wr_data = '0;
  logic done;
  logic signed [47:0] result_a, result_b, result_c, result_d;
  logic [1:0] status;

  quadratic_free_energy_eval uut (.*);

  always #2 clk = ~clk;

  // register copies kept by the predictor
  longint t_ref, a_liq, ceq_liq, m_liq, a_sol, ceq_sol, m_sol;
  bit sat_seen;
  energy_res_t pending[$];
  int errors = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  function automatic longint clampv(longint v);
    if (v > MAXV) begin sat_seen = 1'b1; return MAXV; end
    if (v < MINV) begin sat_seen = 1'b1; return MINV; end
    return v;
  endfunction

  function automatic logic [95:0] magn(longint v);
    return v < 0 ? 96'(-v) : 96'(v);
  endfunction

  function automatic longint from_mag(bit neg, logic [95:0] m);
    if (neg) begin
      if (m > 96'h8000_0000_0000) begin sat_seen = 1'b1; return MINV; end
      return -longint'(m[63:0]);
    end
    if (m > 96'h7FFF_FFFF_FFFF) begin sat_seen = 1'b1; return MAXV; end
    return longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [95:0] p;
    p = magn(a) * magn(b);
    return from_mag((a < 0) != (b < 0), p >> FRAC);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    logic [95:0] q;
    q = (magn(n) << FRAC) / magn(d);
    return from_mag((n < 0) != (d < 0), q);
  endfunction

  function automatic longint eq_conc(bit solid, longint temp);
    longint dt;
    dt = temp - t_ref;
    if (solid) return clampv(ceq_sol + fx_mul(dt, m_sol));
    return clampv(ceq_liq + fx_mul(dt, m_liq));
  endfunction

  function automatic longint phase_energy(longint a, longint ceq, longint c, bit grand);
    longint d, t, fe, der;
    d = clampv(c - ceq);
    t = fx_mul(a, d);
    fe = fx_mul(t, d);
    if (grand) begin
      der = clampv(2 * t);
      fe = clampv(fe - fx_mul(der, c));
    end
    return fe;
  endfunction

  function automatic energy_res_t predict_eval(logic [2:0] op, bit solid, bit grand,
                                               longint temp, longint c, longint h);
    energy_res_t r;
    longint ra, rb, rc, rd, a, g, cl0, cs0, den, nl, ns;
    logic [1:0] st;
    ra = 0; rb = 0; rc = 0; rd = 0; st = qfe_pkg::ST_OK;
    sat_seen = 1'b0;
    a = solid ? a_sol : a_liq;
    case (op)
      qfe_pkg::OP_ENERGY: ra = phase_energy(a, eq_conc(solid, temp), c, grand);
      qfe_pkg::OP_DERIV: ra = clampv(2 * fx_mul(a, clampv(c - eq_conc(solid, temp))));
      qfe_pkg::OP_SECOND: ra = clampv(2 * a);
      qfe_pkg::OP_SPLIT: begin
        g = clampv(ONE - h);
        cl0 = eq_conc(1'b0, temp);
        cs0 = eq_conc(1'b1, temp);
        den = clampv(fx_mul(g, a_sol) + fx_mul(h, a_liq));
        if (a_liq == 0 || a_sol == 0 || den == 0) begin
          st = qfe_pkg::ST_ZERODIV;
        end else begin
          nl = clampv(fx_mul(a_sol, c) - fx_mul(h, clampv(fx_mul(a_sol, cs0) -
                                                          fx_mul(a_liq, cl0))));
          ns = clampv(fx_mul(a_liq, c) - fx_mul(g, clampv(fx_mul(a_liq, cl0) -
                                                          fx_mul(a_sol, cs0))));
          ra = fx_div(nl, den);
          rb = fx_div(ns, den);
          rc = phase_energy(a_liq, cl0, ra, 1'b0);
          rd = phase_energy(a_sol, cs0, rb, 1'b0);
        end
      end
      qfe_pkg::OP_EQ: begin
        ra = eq_conc(1'b0, temp);
        rb = eq_conc(1'b1, temp);
      end
      default: ;
    endcase
    if (st == qfe_pkg::ST_OK && sat_seen) st = qfe_pkg::ST_SAT;
    r.ra = ra[47:0]; r.rb = rb[47:0]; r.rc = rc[47:0]; r.rd = rd[47:0]; r.st = st;
    return r;
  endfunction

  // register writes and accepted items, seen at the edge that moves them
  always @(posedge clk) begin
    if (rst) begin
      t_ref <= 0; a_liq <= ONE; ceq_liq <= 0; m_liq <= 0;
      a_sol <= ONE; ceq_sol <= 0; m_sol <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          qfe_pkg::REG_REF_TEMP: t_ref <= longint'(wr_data[46:0]);
          qfe_pkg::REG_LIQ_CURV: a_liq <= longint'($signed(wr_data));
          qfe_pkg::REG_LIQ_EQ: ceq_liq <= longint'($signed(wr_data));
          qfe_pkg::REG_LIQ_SLOPE: m_liq <= longint'($signed(wr_data));
          qfe_pkg::REG_SOL_CURV: a_sol <= longint'($signed(wr_data));
          qfe_pkg::REG_SOL_EQ: ceq_sol <= longint'($signed(wr_data));
          qfe_pkg::REG_SOL_SLOPE: m_sol <= longint'($signed(wr_data));
          default: ;
        endcase
      end
      if (start && !busy)
        pending.push_back(predict_eval(opcode, phase_sel, grand_flag,
                                       longint'(temperature), longint'(concentration),
                                       longint'(phase_fraction)));
    end
  end

  // result checker
  always @(posedge clk) begin
    energy_res_t e;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending.pop_front();
        if (result_a !== e.ra || result_b !== e.rb || result_c !== e.rc ||
            result_d !== e.rd || status !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp a=%h b=%h c=%h d=%h st=%0d got a=%h b=%h c=%h d=%h st=%0d",
                     e.ra, e.rb, e.rc, e.rd, e.st,
                     result_a, result_b, result_c, result_d, status);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    case ($urandom_range(0, 5))
      0: return 48'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      2: return 48'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 48'($signed(32'($urandom_range(0, 32'h0800_0000))) - 32'sh0400_0000);
    endcase
  endfunction

  task automatic send_item(logic [2:0] op, bit sel, bit grand, logic [46:0] temp,
                           logic [47:0] c, logic [47:0] h);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op; phase_sel <= sel; grand_flag <= grand;
    temperature <= temp; concentration <= c; phase_fraction <= h;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int n);
    logic [2:0] op;
    repeat (n) begin
      op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
      send_item(op, 1'($urandom), 1'($urandom), 47'({$urandom, $urandom} >> $urandom_range(0, 40)),
                rand48(), rand48());
    end
  endtask

  task automatic test_reset_defaults();
    send_item(qfe_pkg::OP_ENERGY, 1'b0, 1'b0, 47'd0, 48'sd0, 48'sd0);
    send_item(qfe_pkg::OP_ENERGY, 1'b1, 1'b1, 47'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'sd0);
    send_item(qfe_pkg::OP_ENERGY, 1'b0, 1'b1, 47'd0, 48'sd2 <<< FRAC, 48'sd0);
    send_item(qfe_pkg::OP_DERIV, 1'b0, 1'b0, 47'd0, 48'h8000_0000_0000, 48'sd0);
    send_item(qfe_pkg::OP_DERIV, 1'b1, 1'b0, 47'd5, -(48'sd3 <<< FRAC), 48'sd0);
    send_item(qfe_pkg::OP_SECOND, 1'b0, 1'b0, 47'd0, 48'sd0, 48'sd0);
    send_item(qfe_pkg::OP_SECOND, 1'b1, 1'b0, 47'd0, 48'sd0, 48'sd0);
    send_item(qfe_pkg::OP_SPLIT, 1'b0, 1'b0, 47'd0, 48'sd1 <<< 23, 48'sd1 <<< 23);
    send_item(qfe_pkg::OP_SPLIT, 1'b0, 1'b0, 47'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    send_item(qfe_pkg::OP_SPLIT, 1'b1, 1'b1, 47'd0, 48'sd0, 48'h7FFF_FFFF_FFFF);
    send_item(qfe_pkg::OP_EQ, 1'b0, 1'b0, 47'h7FFF_FFFF_FFFF, 48'sd0, 48'sd0);
    for (int k = 1; k <= 3; k++)
      send_item(3'(qfe_pkg::OP_EQ + k), 1'b1, 1'b1, 47'd1, 48'sd1, 48'sd1);
    drain();
  endtask

  task automatic test_split_zero_divisor();
    // opposite curvatures cancel at half fraction; zero liquid curvature always
    write_reg(qfe_pkg::REG_LIQ_CURV, -(48'sd1 <<< FRAC));
    write_reg(qfe_pkg::REG_LIQ_SLOPE, 48'sd1 <<< 20);
    write_reg(qfe_pkg::REG_SOL_SLOPE, -(48'sd1 <<< 20));
    send_item(qfe_pkg::OP_SPLIT, 1'b0, 1'b0, 47'd100 <<< FRAC, 48'sd1 <<< 22, 48'sd1 <<< 23);
    send_item(qfe_pkg::OP_SPLIT, 1'b0, 1'b0, 47'd100 <<< FRAC, 48'sd1 <<< 22, 48'sd1 <<< 21);
    send_item(qfe_pkg::OP_EQ, 1'b0, 1'b0, 47'd100 <<< FRAC, 48'sd0, 48'sd0);
    drain();
    write_reg(qfe_pkg::REG_LIQ_CURV, 48'sd0);
    send_item(qfe_pkg::OP_SPLIT, 1'b0, 1'b0, 47'd3, 48'sd1 <<< 22, 48'sd1 <<< 22);
    send_item(qfe_pkg::OP_SECOND, 1'b0, 1'b0, 47'd3, 48'sd0, 48'sd0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(qfe_pkg::REG_REF_TEMP, 48'h7FFF_FFFF_FFFF);
    write_reg(qfe_pkg::REG_LIQ_CURV, 48'h7FFF_FFFF_FFFF);
    write_reg(qfe_pkg::REG_LIQ_EQ, 48'h8000_0000_0000);
    write_reg(qfe_pkg::REG_LIQ_SLOPE, 48'h7FFF_FFFF_FFFF);
    write_reg(qfe_pkg::REG_SOL_CURV, 48'h8000_0000_0000);
    write_reg(qfe_pkg::REG_SOL_EQ, 48'h7FFF_FFFF_FFFF);
    write_reg(qfe_pkg::REG_SOL_SLOPE, 48'h8000_0000_0000);
    send_random(40);
    drain();
  endtask

  task automatic test_random_sweeps();
    for (int phase = 0; phase < 6; phase++) begin
      idle_on = (phase != 2);
      write_reg(qfe_pkg::REG_REF_TEMP, 48'($urandom_range(0, 1000)) <<< FRAC);
      write_reg(qfe_pkg::REG_LIQ_CURV, $urandom_range(0, 7) == 0 ? 48'sd0 : rand48());
      write_reg(qfe_pkg::REG_LIQ_EQ, rand48());
      write_reg(qfe_pkg::REG_LIQ_SLOPE, rand48() >>> $urandom_range(0, 24));
      write_reg(qfe_pkg::REG_SOL_CURV, $urandom_range(0, 7) == 0 ? 48'sd0 : rand48());
      write_reg(qfe_pkg::REG_SOL_EQ, rand48());
      write_reg(qfe_pkg::REG_SOL_SLOPE, rand48() >>> $urandom_range(0, 24));
      send_random(190);
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_split_zero_divisor();
    test_register_extremes();
    test_random_sweeps();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: quadratic_free_energy_eval.f
hdl/qfe_pkg.sv
hdl/qfe_fmul.sv
hdl/qfe_fdiv.sv
hdl/qfe_delay.sv
hdl/quadratic_free_energy_eval.sv
sim/tb_quadratic_free_energy_eval.sv
